/* rtl/particle_grid_binner_assert.svh */
// Assertion macros shared by the particle grid binner RTL.
`ifndef PARTICLE_GRID_BINNER_ASSERT_SVH
`define PARTICLE_GRID_BINNER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PGB_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PGB_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pgb_pkg.sv */
// Package with the types, constants and helper functions of the particle grid binner.
package pgb_pkg;

    // Design constants.
    localparam int MAX_CELLS_PER_AXIS = 16;
    localparam int CELL_CAPACITY      = 64;
    localparam int COORD_WIDTH        = 32;

    localparam int AXES       = 3;
    localparam int AXIS_X     = 0;
    localparam int AXIS_Y     = 1;
    localparam int AXIS_Z     = 2;
    localparam int AXIS_SEL_W = $clog2(AXES);

    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int SCALE_W    = 32;
    localparam int CNT_W      = 5;
    localparam int CELLS_W    = AXES * CNT_W;

    localparam int FRAC_SHIFT = 16 + 24;
    localparam int DIFF_W     = COORD_WIDTH + 1;
    localparam int PROD_W     = COORD_WIDTH + SCALE_W;
    localparam int Q_W        = PROD_W - FRAC_SHIFT;
    localparam int AXIS_IDX_W = (MAX_CELLS_PER_AXIS > 1) ? $clog2(MAX_CELLS_PER_AXIS) : 1;

    localparam int CELL_W     = 12;
    localparam int CELL_DEPTH = 1 << CELL_W;
    localparam int FILL_W     = $clog2(CELL_CAPACITY + 1);
    localparam int SLOT_W     = 6;
    localparam int FILL_OUT_W = 7;

    localparam int S_TDATA_W  = ((AXES * COORD_WIDTH + 7) / 8) * 8;
    localparam int M_FIELDS_W = CELL_W + SLOT_W + FILL_OUT_W + AXES * COORD_WIDTH;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_TUSER_W  = 2;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0100_0000;
    localparam logic [CELLS_W-1:0] CELLS_RESET = 15'd16912;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_ORIGIN = 3'd0,
        REG_Y_ORIGIN = 3'd1,
        REG_Z_ORIGIN = 3'd2,
        REG_X_SCALE  = 3'd3,
        REG_Y_SCALE  = 3'd4,
        REG_Z_SCALE  = 3'd5,
        REG_CELLS    = 3'd6
    } cfg_reg_t;

    // Register file contents.
    typedef struct packed {
        logic [AXES-1:0][COORD_WIDTH-1:0] origin;
        logic [AXES-1:0][SCALE_W-1:0]     scale;
        logic [CELLS_W-1:0]               cells;
    } cfg_t;

    // One accepted particle.
    typedef struct packed {
        logic [AXES-1:0][COORD_WIDTH-1:0] pos;
        logic                             last;
    } item_t;

    // Cell mapping result handed to the fill counter.
    typedef struct packed {
        logic              valid;
        logic [CELL_W-1:0] cell_num;
        logic              below;
    } map_res_t;

    // Status of the fill counter.
    typedef struct packed {
        logic ready;
        logic done;
    } fill_stat_t;

    // Effective cell count of one axis: zero acts as one, large values saturate.
    function automatic logic [CNT_W-1:0] axis_count(input logic [CNT_W-1:0] field);
        logic [CNT_W-1:0] n;
        n = field;
        if (field == '0) begin
            n = CNT_W'(1);
        end else if (int'(field) > MAX_CELLS_PER_AXIS) begin
            n = CNT_W'(MAX_CELLS_PER_AXIS);
        end
        return n;
    endfunction

endpackage

/* rtl/pgb_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module pgb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; the read data holds between reads.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/pgb_cfg_regs.sv */
// Configuration register file of the particle grid binner.
module pgb_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [pgb_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [pgb_pkg::CFG_W-1:0]      cfg_wdata,
    output pgb_pkg::cfg_t                  cfg
);
    import pgb_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode a register write; an unused index leaves everything unchanged.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                REG_X_ORIGIN: cfg_next.origin[AXIS_X] = COORD_WIDTH'(cfg_wdata);
                REG_Y_ORIGIN: cfg_next.origin[AXIS_Y] = COORD_WIDTH'(cfg_wdata);
                REG_Z_ORIGIN: cfg_next.origin[AXIS_Z] = COORD_WIDTH'(cfg_wdata);
                REG_X_SCALE:  cfg_next.scale[AXIS_X]  = SCALE_W'(cfg_wdata);
                REG_Y_SCALE:  cfg_next.scale[AXIS_Y]  = SCALE_W'(cfg_wdata);
                REG_Z_SCALE:  cfg_next.scale[AXIS_Z]  = SCALE_W'(cfg_wdata);
                REG_CELLS:    cfg_next.cells          = cfg_wdata[CELLS_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    // Registers with their reset values.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < AXES; a++) begin
                cfg_reg.origin[a] <= '0;
                cfg_reg.scale[a]  <= SCALE_RESET;
            end
            cfg_reg.cells <= CELLS_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/pgb_cell_map.sv */
// Maps one particle position to a linear cell index with a shared multiplier.
`include "particle_grid_binner_assert.svh"

module pgb_cell_map (
    input  logic              aclk,
    input  logic              aresetn,
    input  pgb_pkg::cfg_t     cfg,
    input  pgb_pkg::item_t    item,
    input  logic              start,
    input  logic              take,
    output pgb_pkg::map_res_t res
);
    import pgb_pkg::*;

    typedef enum logic [5:0] {
        M_IDLE  = 6'b000001,
        M_DIFF  = 6'b000010,
        M_MUL   = 6'b000100,
        M_CLAMP = 6'b001000,
        M_LIN   = 6'b010000,
        M_DONE  = 6'b100000
    } map_state_t;

    map_state_t                      state_reg, state_next;
    logic [AXES-1:0][DIFF_W-1:0]     diff_reg, diff_next;
    logic [AXIS_SEL_W-1:0]           axis_reg, axis_next;
    logic [PROD_W-1:0]               prod_reg, prod_next;
    logic [AXES-1:0][AXIS_IDX_W-1:0] idx_reg, idx_next;
    logic [2*CNT_W-1:0]              nyz_reg, nyz_next;
    logic [CELL_W-1:0]               cell_reg, cell_next;

    logic [AXES-1:0][CNT_W-1:0]      n_axis;
    logic [AXES-1:0]                 below;
    logic [CNT_W-1:0]                n_top;
    logic [Q_W-1:0]                  quot;
    logic [AXIS_IDX_W-1:0]           idx_clamped;

    // Axis cell counts and the below-origin flags from the stored differences.
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            n_axis[a] = axis_count(cfg.cells[a*CNT_W +: CNT_W]);
            below[a]  = diff_reg[a][DIFF_W-1];
        end
    end

    // Truncate the scaled offset and clamp it into the axis range.
    always_comb begin
        quot  = prod_reg[PROD_W-1 -: Q_W];
        n_top = n_axis[axis_reg] - CNT_W'(1);
        priority if (below[axis_reg]) begin
            idx_clamped = '0;
        end else if (quot > Q_W'(n_top)) begin
            idx_clamped = AXIS_IDX_W'(n_top);
        end else begin
            idx_clamped = quot[AXIS_IDX_W-1:0];
        end
    end

    // Sequencer: difference, then multiply and clamp per axis, then linearise.
    always_comb begin
        state_next = state_reg;
        diff_next  = diff_reg;
        axis_next  = axis_reg;
        prod_next  = prod_reg;
        idx_next   = idx_reg;
        nyz_next   = nyz_reg;
        cell_next  = cell_reg;
        unique case (state_reg)
            M_IDLE: begin
                if (start) begin
                    state_next = M_DIFF;
                end
            end
            M_DIFF: begin
                for (int a = 0; a < AXES; a++) begin
                    diff_next[a] = {item.pos[a][COORD_WIDTH-1], item.pos[a]}
                                 - {cfg.origin[a][COORD_WIDTH-1], cfg.origin[a]};
                end
                nyz_next   = (2*CNT_W)'(n_axis[AXIS_Y]) * (2*CNT_W)'(n_axis[AXIS_Z]);
                axis_next  = '0;
                state_next = M_MUL;
            end
            M_MUL: begin
                prod_next  = PROD_W'(diff_reg[axis_reg][COORD_WIDTH-1:0])
                           * PROD_W'(cfg.scale[axis_reg]);
                state_next = M_CLAMP;
            end
            M_CLAMP: begin
                idx_next[axis_reg] = idx_clamped;
                if (axis_reg == AXIS_SEL_W'(AXES - 1)) begin
                    state_next = M_LIN;
                end else begin
                    axis_next  = axis_reg + AXIS_SEL_W'(1);
                    state_next = M_MUL;
                end
            end
            M_LIN: begin
                // Wraps modulo the store depth.
                cell_next  = CELL_W'(idx_reg[AXIS_X]) * CELL_W'(nyz_reg)
                           + CELL_W'(idx_reg[AXIS_Y]) * CELL_W'(n_axis[AXIS_Z])
                           + CELL_W'(idx_reg[AXIS_Z]);
                state_next = M_DONE;
            end
            M_DONE: begin
                if (take) begin
                    state_next = M_IDLE;
                end
            end
            default: state_next = M_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        diff_reg <= diff_next;
        axis_reg <= axis_next;
        prod_reg <= prod_next;
        idx_reg  <= idx_next;
        nyz_reg  <= nyz_next;
        cell_reg <= cell_next;
    end

    assign res.valid    = (state_reg == M_DONE);
    assign res.cell_num = cell_reg;
    assign res.below    = |below;

    // A finished mapping holds its cell until the fill counter takes it.
    `PGB_ASSERT_NXT(a_map_res_held, aclk, aresetn, res.valid && !take,
        res.valid && $stable(res.cell_num), "cell mapping result dropped or changed before take")

endmodule

/* rtl/pgb_fill_ctrl.sv */
// Cell fill counter: clearing pass, read-modify-write of the count memory, output register.
`include "particle_grid_binner_assert.svh"

module pgb_fill_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pgb_pkg::item_t                item,
    input  pgb_pkg::map_res_t             map_res,
    output logic                          map_take,
    output pgb_pkg::fill_stat_t           stat,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pgb_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [pgb_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                          m_tlast
);
    import pgb_pkg::*;

    typedef enum logic [2:0] {
        F_CLEAR  = 3'b001,
        F_IDLE   = 3'b010,
        F_UPDATE = 3'b100
    } fill_state_t;

    fill_state_t            state_reg, state_next;
    logic [CELL_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [CELL_W-1:0]      cell_reg, cell_next;
    logic                   below_reg, below_next;
    logic                   out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0]   out_data_reg, out_data_next;
    logic [M_TUSER_W-1:0]   out_user_reg, out_user_next;
    logic                   out_last_reg, out_last_next;

    logic                   mem_we;
    logic [CELL_W-1:0]      mem_waddr;
    logic [FILL_W-1:0]      mem_wdata;
    logic [FILL_W-1:0]      rd_count;
    logic                   full;
    logic                   out_free;
    logic                   fire;
    logic [SLOT_W-1:0]      slot_val;
    logic [FILL_W-1:0]      fill_val;

    // Fill counts, one entry per cell.
    pgb_ram #(
        .WIDTH (FILL_W),
        .DEPTH (CELL_DEPTH)
    ) u_count_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (map_take),
        .raddr (map_res.cell_num),
        .rdata (rd_count)
    );

    // Count update for the cell read when the mapping result was taken.
    always_comb begin
        full     = (rd_count >= FILL_W'(CELL_CAPACITY));
        out_free = !out_valid_reg || m_tready;
        fire     = (state_reg == F_UPDATE) && out_free;
        slot_val = full ? '0 : SLOT_W'(rd_count);
        fill_val = full ? rd_count : rd_count + FILL_W'(1);
        map_take = (state_reg == F_IDLE) && map_res.valid;
    end

    // Memory write: zeros during the clearing pass, the new count on an update.
    always_comb begin
        if (state_reg == F_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = fire && !full;
            mem_waddr = cell_reg;
            mem_wdata = fill_val;
        end
    end

    // Sequencer; only one item is in the read-modify-write at a time.
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        cell_next    = cell_reg;
        below_next   = below_reg;
        unique case (state_reg)
            F_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + CELL_W'(1);
                if (clr_cnt_reg == CELL_W'(CELL_DEPTH - 1)) begin
                    state_next = F_IDLE;
                end
            end
            F_IDLE: begin
                if (map_take) begin
                    cell_next  = map_res.cell_num;
                    below_next = map_res.below;
                    state_next = F_UPDATE;
                end
            end
            F_UPDATE: begin
                if (fire) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_CLEAR;
        endcase
    end

    // Output register: loaded on an update, emptied when the transaction completes.
    always_comb begin
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (fire) begin
            out_valid_next = 1'b1;
            out_data_next  = M_TDATA_W'({item.pos[AXIS_Z], item.pos[AXIS_Y], item.pos[AXIS_X],
                                         FILL_OUT_W'(fill_val), slot_val, cell_reg});
            out_user_next  = {below_reg, full};
            out_last_next  = item.last;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= F_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cell_reg     <= cell_next;
        below_reg    <= below_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

    assign stat.ready = (state_reg != F_CLEAR);
    assign stat.done  = fire;
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser    = out_user_reg;
    assign m_tlast    = out_last_reg;

    // A count written back never passes the cell capacity.
    `PGB_ASSERT_IMP(a_count_in_range, aclk, aresetn, mem_we && (state_reg == F_UPDATE),
        mem_wdata <= FILL_W'(CELL_CAPACITY), "cell fill count written above capacity")

    // A finished update always leaves a result waiting at the output.
    `PGB_ASSERT_NXT(a_done_shows, aclk, aresetn, fire, out_valid_reg,
        "update finished without a pending result")

    // The clearing pass never overlaps an update.
    `PGB_ASSERT_IMP(a_no_take_in_clear, aclk, aresetn, state_reg == F_CLEAR,
        !map_take && !fire, "count update during the clearing pass")

endmodule

/* rtl/particle_grid_binner.sv */
// Top level of the particle grid binner.
//
// Input channel (s_): one particle per transaction, x, y and z in signed Q16.16 on
// s_tdata, the end-of-set marker on s_tlast. Result channel (m_): one result per
// particle with the linear cell index, the slot taken in the cell, the count after
// it and the coordinates; m_tuser flags a dropped particle (full cell) and a
// coordinate clamped below its origin. Registers are to be written on the cfg_ port
// only while no particle is in flight; the block itself does not enforce this.
// An item passes in order through a difference step, a multiply and a clamp step
// for each axis through one shared 32x32 multiplier, a linearising step, then a
// read of the count memory and a write-back, skipped when the cell is full.
// One particle is in work at a time, so successive updates of one cell never overlap.
// After reset a clearing pass writes zero to all 4096 counts, during which s_tready
// is low; register writes are taken as usual.
// A stalled receiver leaves the result in the output register; the next particle is
// still accepted and mapped, and waits before its count update until the output
// register is free.
`include "particle_grid_binner_assert.svh"

module particle_grid_binner (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write port.
    input  logic                          cfg_we,
    input  logic [pgb_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [pgb_pkg::CFG_W-1:0]     cfg_wdata,
    // Particle input.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pgb_pkg::S_TDATA_W-1:0] s_tdata,  // px, py, pz
    input  logic                          s_tlast,  // last_particle
    // Result output.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pgb_pkg::M_TDATA_W-1:0] m_tdata,  // cell_number, slot, fill_after,
                                                    // out_x, out_y, out_z
    output logic [pgb_pkg::M_TUSER_W-1:0] m_tuser,  // overflowed, below_range
    output logic                          m_tlast   // last_out
);
    import pgb_pkg::*;

    cfg_t       cfg;
    item_t      item_reg, item_next;
    logic       busy_reg, busy_next;
    logic       accept;
    map_res_t   map_res;
    logic       map_take;
    fill_stat_t fill_stat;

    // Register file.
    pgb_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Input transaction capture; the particle is held until its count is updated.
    always_comb begin
        s_tready  = !busy_reg && fill_stat.ready;
        accept    = s_tvalid && s_tready;
        item_next = item_reg;
        busy_next = busy_reg;
        if (accept) begin
            for (int a = 0; a < AXES; a++) begin
                item_next.pos[a] = s_tdata[a*COORD_WIDTH +: COORD_WIDTH];
            end
            item_next.last = s_tlast;
            busy_next      = 1'b1;
        end else if (fill_stat.done) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    // Position to cell index.
    pgb_cell_map u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item    (item_reg),
        .start   (accept),
        .take    (map_take),
        .res     (map_res)
    );

    // Fill counts and result register.
    pgb_fill_ctrl u_fill (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .item     (item_reg),
        .map_res  (map_res),
        .map_take (map_take),
        .stat     (fill_stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // A count update only ever belongs to a particle that is in flight.
    `PGB_ASSERT_IMP(a_done_while_busy, aclk, aresetn, fill_stat.done, busy_reg,
        "count update without a particle in flight")

endmodule
